// ----- hdl/dmpsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpsc_pkg
// Shared types, codes and constants for the dual motor PI speed controller.
// ----------------------------------------------------------------------------
package dmpsc_pkg;

  // drive command codes
  typedef enum logic [2:0] {
    FN_SET        = 3'd0,
    FN_FWD        = 3'd1,
    FN_BACK       = 3'd2,
    FN_FWD_LEFT   = 3'd3,
    FN_BACK_LEFT  = 3'd4,
    FN_FWD_RIGHT  = 3'd5,
    FN_BACK_RIGHT = 3'd6,
    FN_STOP       = 3'd7
  } func_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_KP          = 3'd0,
    REG_KI          = 3'd1,
    REG_PPR         = 3'd2,
    REG_PERIOD      = 3'd3,
    REG_INT_LIMIT   = 3'd4,
    REG_TURN_INNER  = 3'd5,
    REG_TURN_OUTER  = 3'd6
  } reg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LAUNCH,
    ST_DIV,
    ST_PI_GO,
    ST_PI,
    ST_WRITE
  } state_t;

  // per-lane control from the sequencer
  typedef struct packed {
    logic mult;
    logic div_start;
    logic pi_start;
  } lane_ctl_t;

  // per-lane status back to the sequencer
  typedef struct packed {
    logic div_done;
    logic pi_done;
  } lane_stat_t;

  // rpm scale: 60000 ms/min times 256 for Q.8
  localparam int unsigned SCALE_W     = 24;
  localparam logic [SCALE_W-1:0] SPEED_SCALE = 24'd15360000;

  // divider widths
  localparam int unsigned NUM_W = 55;
  localparam int unsigned DEN_W = 48;
  localparam int unsigned QUO_W = 24;
  localparam int unsigned CNT_W = 5;

  // datapath widths
  localparam int unsigned SPD_W    = 24;
  localparam int unsigned TGT_W    = 20;
  localparam int unsigned INTEG_W  = 18;
  localparam int unsigned ADJ_W    = 26;

  localparam logic [QUO_W-1:0] SPD_POS_MAX = 24'h7FFFFF;
  localparam logic [QUO_W-1:0] SPD_NEG_MAG = 24'h800000;

  // reset values of the configuration registers
  localparam logic [15:0] KP_RESET     = 16'd353;
  localparam logic [15:0] KI_RESET     = 16'd8;
  localparam logic [15:0] PPR_RESET    = 16'd2400;
  localparam logic [15:0] PERIOD_RESET = 16'd1000;
  localparam logic [7:0]  LIMIT_RESET  = 8'd255;
  localparam logic [8:0]  INNER_RESET  = 9'd51;
  localparam logic [8:0]  OUTER_RESET  = 9'd205;
  localparam logic [8:0]  UNITY_GAIN   = 9'd256;

endpackage

// ----- hdl/dmpsc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpsc_div
// Restoring unsigned divider, one quotient bit per cycle, with overflow flag
// when the quotient does not fit in QUO_W bits.
// ----------------------------------------------------------------------------
module dmpsc_div
  import dmpsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quot,
  output logic             ovf
);

  localparam int unsigned DSR_W = DEN_W + QUO_W - 1;
  localparam int unsigned CMP_W = DEN_W + QUO_W;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W-1:0] rem_ext;
  logic [DSR_W-1:0] rem_diff;
  logic             fits;
  logic             too_big;

  // quotient needs more than QUO_W bits
  assign too_big  = CMP_W'(num) >= {den, {QUO_W{1'b0}}};

  // one restoring step
  assign rem_ext  = DSR_W'(rem);
  assign fits     = rem_ext >= dsr;
  assign rem_diff = rem_ext - dsr;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsr  <= {den, {(QUO_W-1){1'b0}}};
      quot <= '0;
      ovf  <= too_big;
    end else if (busy) begin
      rem  <= fits ? rem_diff[NUM_W-1:0] : rem;
      dsr  <= dsr >> 1;
      quot <= {quot[QUO_W-2:0], fits};
    end
  end

endmodule

// ----- hdl/dmpsc_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpsc_lane
// One motor: speed measurement from the encoder count and the PI step with
// a clamped integrator.
// ----------------------------------------------------------------------------
module dmpsc_lane
  import dmpsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  lane_ctl_t                ctl,
  output lane_stat_t               stat,
  input  logic signed [31:0]       count,
  input  logic [DEN_W-1:0]         den,
  input  logic signed [TGT_W-1:0]  target,
  input  logic [15:0]              kp,
  input  logic [15:0]              ki,
  input  logic [7:0]               limit,
  output logic signed [SPD_W-1:0]  speed,
  output logic signed [ADJ_W-1:0]  adj
);

  logic signed [55:0]          prod;
  logic signed [55:0]          prod_neg;
  logic [NUM_W-1:0]            mag;
  logic                        neg;
  logic                        div_done;
  logic [QUO_W-1:0]            quot;
  logic                        ovf;
  logic                        clip;
  logic signed [SPD_W-1:0]     speed_next;

  logic signed [24:0]          err_c;
  logic signed [25:0]          sum_c;
  logic signed [25:0]          lim_c;
  logic signed [INTEG_W-1:0]   acc_c;
  logic signed [24:0]          err;
  logic signed [INTEG_W-1:0]   integ;
  logic signed [40:0]          p_term;
  logic signed [33:0]          i_term;
  logic signed [41:0]          sum_pi;
  logic signed [41:0]          sum_rnd;
  logic                        v1, v2, v3;

  // numerator magnitude for the divider
  assign prod_neg = -prod;
  assign mag      = prod[55] ? prod_neg[NUM_W-1:0] : prod[NUM_W-1:0];

  dmpsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   (mag),
    .den   (den),
    .done  (div_done),
    .quot  (quot),
    .ovf   (ovf)
  );

  // signed quotient saturated to the speed range
  always_comb begin
    if (neg) begin
      clip       = ovf || (quot > SPD_NEG_MAG);
      speed_next = clip ? $signed(SPD_NEG_MAG) : $signed(-quot);
    end else begin
      clip       = ovf || (quot > SPD_POS_MAX);
      speed_next = clip ? $signed(SPD_POS_MAX) : $signed(quot);
    end
  end

  // error and clamped integrator
  assign err_c = 25'(target) - 25'(speed);
  assign sum_c = 26'(integ) + 26'(err_c);
  assign lim_c = $signed({10'b0, limit, 8'b0});

  always_comb begin
    if (sum_c > lim_c) begin
      acc_c = lim_c[INTEG_W-1:0];
    end else if (sum_c < -lim_c) begin
      acc_c = INTEG_W'(-lim_c);
    end else begin
      acc_c = sum_c[INTEG_W-1:0];
    end
  end

  // sum of terms, divided by 65536 toward zero
  assign sum_pi  = 42'(p_term) + 42'(i_term);
  assign sum_rnd = sum_pi + (sum_pi[41] ? 42'sd65535 : 42'sd0);

  // state and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= '0;
      integ <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
    end else begin
      if (div_done) begin
        speed <= speed_next;
      end
      if (ctl.pi_start) begin
        integ <= acc_c;
      end
      v1 <= ctl.pi_start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.mult) begin
      prod <= 56'(count) * 56'($signed({1'b0, SPEED_SCALE}));
    end
    if (ctl.div_start) begin
      neg <= prod[55];
    end
    if (ctl.pi_start) begin
      err <= err_c;
    end
    if (v1) begin
      p_term <= 41'($signed({1'b0, kp})) * 41'(err);
      i_term <= 34'($signed({1'b0, ki})) * 34'(integ);
    end
    if (v2) begin
      adj <= sum_rnd[41:16];
    end
  end

  assign stat.div_done = div_done;
  assign stat.pi_done  = v3;

endmodule

// ----- hdl/dual_motor_pi_speed_control.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_motor_pi_speed_control
// Two-motor PI speed controller: command decode, target mapping, a speed and
// PI lane per motor, and a merge stage that picks forward, reverse or brake.
//
//   channel  dir  handshake         contents
//   s_*      in   tvalid/tready     tuser: func; tdata: speed, time, counts
//   m_*      out  tvalid/tready     tdata: drive levels, clear, speeds, flag
//   cfg_*    in   cfg_we            cfg_addr register index, cfg_wdata value
//
// A set value command gives no result. Other commands pass through the
// prepare and launch states, the 24-step restoring divider in each lane when
// a speed measurement is due, and the PI pipeline before the write state.
// Reset is synchronous; the configuration registers return to their defaults.
// A result waits in the output register while the next command is accepted.
// ----------------------------------------------------------------------------
module dual_motor_pi_speed_control
  import dmpsc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  // command stream
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [2:0]    s_tuser,    // func
  input  logic [103:0]  s_tdata,    // speed_value, now_ms, enc_count_left,
                                    // enc_count_right
  // result stream
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [87:0]   m_tdata,    // fwd_drive_left, rev_drive_left,
                                    // fwd_drive_right, rev_drive_right,
                                    // clear_encoders, speed_left, speed_right,
                                    // drive_saturated, zero fill
  // configuration
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [15:0]   cfg_wdata
);

  // configuration registers
  logic [15:0] kp_gain;
  logic [15:0] ki_gain;
  logic [15:0] pulses_per_rev;
  logic [15:0] measure_period_ms;
  logic [7:0]  integrator_limit;
  logic [8:0]  turn_inner_gain;
  logic [8:0]  turn_outer_gain;

  // controller state
  state_t             state, state_next;
  logic [31:0]        last_measure_time;
  logic signed [7:0]  stored_speed;

  // captured command
  func_t              func;
  logic [31:0]        now;
  logic [31:0]        delta;
  logic               meas;
  logic signed [31:0] count_left;
  logic signed [31:0] count_right;
  logic [DEN_W-1:0]   den;
  logic signed [TGT_W-1:0] target_left;
  logic signed [TGT_W-1:0] target_right;

  logic               s_accept;
  logic               out_load;
  lane_ctl_t          ctl;
  lane_stat_t         stat_left, stat_right;
  logic signed [SPD_W-1:0] speed_left, speed_right;
  logic signed [ADJ_W-1:0] adj_left, adj_right;

  logic [15:0]        ppr_eff;
  logic [15:0]        period_eff;
  logic [31:0]        delta_in;

  logic signed [9:0]  x;
  logic signed [9:0]  x_off;
  logic signed [13:0] x_mul;
  logic signed [13:0] x_div;
  logic signed [10:0] mapped;
  logic [8:0]         gain_left, gain_right;
  logic signed [TGT_W-1:0] tgt_left_c, tgt_right_c;

  logic signed [ADJ_W-1:0] neg_left, neg_right;
  logic [7:0]         fwd_left, rev_left, fwd_right, rev_right;
  logic               sat;

  assign s_accept   = s_tvalid && s_tready;
  assign ppr_eff    = (pulses_per_rev == 16'd0) ? 16'd1 : pulses_per_rev;
  assign period_eff = (measure_period_ms == 16'd0) ? 16'd1 : measure_period_ms;
  assign delta_in   = s_tdata[39:8] - last_measure_time;

  // speed selection by command
  always_comb begin
    case (func)
      FN_STOP:                            x = '0;
      FN_BACK, FN_BACK_LEFT, FN_BACK_RIGHT: x = -10'(stored_speed);
      default:                            x = 10'(stored_speed);
    endcase
  end

  // map -60..60 rpm onto -255..255: (x + 60) * 17 / 4 - 255, toward zero
  assign x_off  = x + 10'sd60;
  assign x_mul  = 14'(x_off) * 14'sd17;
  assign x_div  = x_mul[13] ? ((x_mul + 14'sd3) >>> 2) : (x_mul >>> 2);
  assign mapped = 11'(x_div - 14'sd255);

  // per-side target gain
  always_comb begin
    case (func)
      FN_FWD_LEFT, FN_BACK_LEFT: begin
        gain_left  = turn_inner_gain;
        gain_right = turn_outer_gain;
      end
      FN_FWD_RIGHT, FN_BACK_RIGHT: begin
        gain_left  = turn_outer_gain;
        gain_right = turn_inner_gain;
      end
      default: begin
        gain_left  = UNITY_GAIN;
        gain_right = UNITY_GAIN;
      end
    endcase
  end

  assign tgt_left_c  = TGT_W'(mapped) * TGT_W'($signed({1'b0, gain_left}));
  assign tgt_right_c = TGT_W'(mapped) * TGT_W'($signed({1'b0, gain_right}));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_accept && (func_t'(s_tuser) != FN_SET)) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP:   state_next = ST_LAUNCH;
      ST_LAUNCH: state_next = meas ? ST_DIV : ST_PI;
      ST_DIV: begin
        if (stat_left.div_done) begin
          state_next = ST_PI_GO;
        end
      end
      ST_PI_GO:  state_next = ST_PI;
      ST_PI: begin
        if (stat_left.pi_done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready      = 1'b0;
    out_load      = 1'b0;
    ctl.mult      = 1'b0;
    ctl.div_start = 1'b0;
    ctl.pi_start  = 1'b0;
    case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_PREP:   ctl.mult = 1'b1;
      ST_LAUNCH: begin
        ctl.div_start = meas;
        ctl.pi_start  = !meas;
      end
      ST_PI_GO:  ctl.pi_start = 1'b1;
      ST_WRITE:  out_load = !m_tvalid || m_tready;
      default:   s_tready = 1'b0;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      m_tvalid          <= 1'b0;
      last_measure_time <= '0;
      stored_speed      <= '0;
      kp_gain           <= KP_RESET;
      ki_gain           <= KI_RESET;
      pulses_per_rev    <= PPR_RESET;
      measure_period_ms <= PERIOD_RESET;
      integrator_limit  <= LIMIT_RESET;
      turn_inner_gain   <= INNER_RESET;
      turn_outer_gain   <= OUTER_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_KP:         kp_gain           <= cfg_wdata;
          REG_KI:         ki_gain           <= cfg_wdata;
          REG_PPR:        pulses_per_rev    <= cfg_wdata;
          REG_PERIOD:     measure_period_ms <= cfg_wdata;
          REG_INT_LIMIT:  integrator_limit  <= cfg_wdata[7:0];
          REG_TURN_INNER: turn_inner_gain   <= cfg_wdata[8:0];
          REG_TURN_OUTER: turn_outer_gain   <= cfg_wdata[8:0];
          default:        kp_gain           <= kp_gain;
        endcase
      end
      if (s_accept && (func_t'(s_tuser) == FN_SET)) begin
        stored_speed <= s_tdata[7:0];
      end
      if ((state == ST_DIV) && stat_left.div_done) begin
        last_measure_time <= now;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // command capture and prepared operands
  always_ff @(posedge clk) begin
    if (s_accept) begin
      func        <= func_t'(s_tuser);
      now         <= s_tdata[39:8];
      count_left  <= s_tdata[71:40];
      count_right <= s_tdata[103:72];
      delta       <= delta_in;
      meas        <= delta_in >= 32'(period_eff);
    end
    if (state == ST_PREP) begin
      den          <= DEN_W'(ppr_eff) * DEN_W'(delta);
      target_left  <= tgt_left_c;
      target_right <= tgt_right_c;
    end
    if (out_load) begin
      m_tdata <= {6'b0, sat, speed_right, speed_left, meas,
                  rev_right, fwd_right, rev_left, fwd_left};
    end
  end

  dmpsc_lane u_lane_left (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .stat   (stat_left),
    .count  (count_left),
    .den    (den),
    .target (target_left),
    .kp     (kp_gain),
    .ki     (ki_gain),
    .limit  (integrator_limit),
    .speed  (speed_left),
    .adj    (adj_left)
  );

  dmpsc_lane u_lane_right (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .stat   (stat_right),
    .count  (count_right),
    .den    (den),
    .target (target_right),
    .kp     (kp_gain),
    .ki     (ki_gain),
    .limit  (integrator_limit),
    .speed  (speed_right),
    .adj    (adj_right)
  );

  // merge: both forward, both reverse, or brake
  assign neg_left  = -adj_left;
  assign neg_right = -adj_right;

  always_comb begin
    fwd_left  = '0;
    rev_left  = '0;
    fwd_right = '0;
    rev_right = '0;
    sat       = 1'b0;
    if ((adj_left > 26'sd0) && (adj_right > 26'sd0)) begin
      fwd_left  = (adj_left > 26'sd255) ? 8'd255 : adj_left[7:0];
      fwd_right = (adj_right > 26'sd255) ? 8'd255 : adj_right[7:0];
      sat       = (adj_left > 26'sd255) || (adj_right > 26'sd255);
    end else if ((adj_left < 26'sd0) && (adj_right < 26'sd0)) begin
      rev_left  = (neg_left > 26'sd255) ? 8'd255 : neg_left[7:0];
      rev_right = (neg_right > 26'sd255) ? 8'd255 : neg_right[7:0];
      sat       = (neg_left > 26'sd255) || (neg_right > 26'sd255);
    end
  end

  // lanes run in lock step
  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    (stat_left.div_done == stat_right.div_done) &&
    (stat_left.pi_done == stat_right.pi_done))
    else $error("lanes out of step");

  // a PI result only arrives while the sequencer waits for it
  a_pi_done_in_pi: assert property (@(posedge clk) disable iff (rst)
    stat_left.pi_done |-> (state == ST_PI))
    else $error("PI result outside PI wait");

  // a motor is never driven forward and reverse at once
  a_drive_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !((m_tdata[7:0] != 8'd0) && (m_tdata[15:8] != 8'd0)) &&
                 !((m_tdata[23:16] != 8'd0) && (m_tdata[31:24] != 8'd0)))
    else $error("forward and reverse drive together");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual motor PI speed controller. Drive commands
// go in on the command stream with random content and random gaps, and the
// results are compared field by field against a local speed/PI predictor.
// The run covers default, extreme and random register settings, and holds
// off the result stream for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module testbench
  import dmpsc_pkg::*;
;

  // unmapped register index, writes to it must be ignored
  localparam logic [2:0] REG_UNUSED = 3'd7;
  // 60000 ms per minute times 256 for Q.8
  localparam longint RPM_SCALE = 64'sd15360000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [7:0]  fwd_l;
    logic [7:0]  rev_l;
    logic [7:0]  fwd_r;
    logic [7:0]  rev_r;
    logic        clr;
    logic [23:0] spd_l;
    logic [23:0] spd_r;
    logic        sat;
  } drive_result_t;

  // predictor of the controller plus the queue of drive results still due
  class speed_ctrl_scoreboard;
    logic [15:0] kp, ki, ppr, period;
    logic [7:0] limit;
    logic [8:0] inner, outer;
    logic [31:0] last_meas_ms;
    logic signed [23:0] meas_spd [2];
    logic signed [17:0] integ [2];
    logic signed [7:0] stored_rpm;
    drive_result_t due_q [$];
    int errors;

    function new();
      kp = KP_RESET;
      ki = KI_RESET;
      ppr = PPR_RESET;
      period = PERIOD_RESET;
      limit = LIMIT_RESET;
      inner = INNER_RESET;
      outer = OUTER_RESET;
      last_meas_ms = '0;
      meas_spd[0] = '0;
      meas_spd[1] = '0;
      integ[0] = '0;
      integ[1] = '0;
      stored_rpm = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_KP:         kp = val;
        REG_KI:         ki = val;
        REG_PPR:        ppr = val;
        REG_PERIOD:     period = val;
        REG_INT_LIMIT:  limit = val[7:0];
        REG_TURN_INNER: inner = val[8:0];
        REG_TURN_OUTER: outer = val[8:0];
        default: ;
      endcase
    endfunction

    // encoder count over dt ms to rpm Q.8, saturated to 24 bits
    function logic signed [23:0] rpm_from_count(longint cnt, longint dt);
      longint den, q;
      den = (ppr == 0) ? 1 : ppr;
      den = den * dt;
      q = (cnt * RPM_SCALE) / den;
      if (q > 64'sd8388607) q = 64'sd8388607;
      else if (q < -64'sd8388608) q = -64'sd8388608;
      return q[23:0];
    endfunction

    // one PI update, returns the adjustment in drive units
    function longint pi_adjust(int side, longint tgt);
      longint err, lim, acc, kp_l, ki_l;
      err = tgt - longint'(meas_spd[side]);
      lim = limit;
      lim = lim * 256;
      acc = longint'(integ[side]) + err;
      if (acc > lim) acc = lim;
      else if (acc < -lim) acc = -lim;
      integ[side] = acc[17:0];
      kp_l = kp;
      ki_l = ki;
      return (kp_l * err + ki_l * acc) / 65536;
    endfunction

    function logic [7:0] drive_level(longint v);
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function void note_command(func_t fn, logic [103:0] data);
      logic signed [7:0] spd_in;
      logic [31:0] ms_stamp, elapsed;
      logic signed [31:0] cnt_l, cnt_r;
      longint rpm, mapped, tgt_l, tgt_r, adj_l, adj_r, gain_in, gain_out, per;
      drive_result_t r;
      {cnt_r, cnt_l, ms_stamp, spd_in} = data;
      if (fn == FN_SET) begin
        stored_rpm = spd_in;
        return;
      end
      // pick the rpm request and map -60..60 onto -255..255
      case (fn)
        FN_STOP: rpm = 0;
        FN_BACK, FN_BACK_LEFT, FN_BACK_RIGHT: rpm = -longint'(stored_rpm);
        default: rpm = stored_rpm;
      endcase
      mapped = (rpm + 60) * 510 / 120 - 255;
      gain_in = inner;
      gain_out = outer;
      // per side target in Q.8
      case (fn)
        FN_FWD_LEFT, FN_BACK_LEFT: begin
          tgt_l = mapped * gain_in;
          tgt_r = mapped * gain_out;
        end
        FN_FWD_RIGHT, FN_BACK_RIGHT: begin
          tgt_l = mapped * gain_out;
          tgt_r = mapped * gain_in;
        end
        default: begin
          tgt_l = mapped * 256;
          tgt_r = mapped * 256;
        end
      endcase
      r = '{default: '0};
      // speed measurement once the period has elapsed
      elapsed = ms_stamp - last_meas_ms;
      per = (period == 0) ? 1 : period;
      if (elapsed >= per) begin
        meas_spd[0] = rpm_from_count(cnt_l, elapsed);
        meas_spd[1] = rpm_from_count(cnt_r, elapsed);
        last_meas_ms = ms_stamp;
        r.clr = 1'b1;
      end
      adj_l = pi_adjust(0, tgt_l);
      adj_r = pi_adjust(1, tgt_r);
      // forward, reverse or brake
      if (adj_l > 0 && adj_r > 0) begin
        r.fwd_l = drive_level(adj_l);
        r.fwd_r = drive_level(adj_r);
        r.sat = (adj_l > 255) || (adj_r > 255);
      end else if (adj_l < 0 && adj_r < 0) begin
        r.rev_l = drive_level(-adj_l);
        r.rev_r = drive_level(-adj_r);
        r.sat = (adj_l < -255) || (adj_r < -255);
      end
      r.spd_l = meas_spd[0];
      r.spd_r = meas_spd[1];
      due_q.push_back(r);
    endfunction

    function void check_field(string name, logic [23:0] want, logic [23:0] got,
                              time t);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", t, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [87:0] data, time t);
      drive_result_t want;
      if (due_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", t, data);
        errors++;
        return;
      end
      want = due_q.pop_front();
      check_field("fwd_drive_left", want.fwd_l, data[7:0], t);
      check_field("rev_drive_left", want.rev_l, data[15:8], t);
      check_field("fwd_drive_right", want.fwd_r, data[23:16], t);
      check_field("rev_drive_right", want.rev_r, data[31:24], t);
      check_field("clear_encoders", want.clr, data[32], t);
      check_field("speed_left", want.spd_l, data[56:33], t);
      check_field("speed_right", want.spd_r, data[80:57], t);
      check_field("drive_saturated", want.sat, data[81], t);
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [2:0]    s_tuser = FN_STOP;   // func
  logic [103:0]  s_tdata = '0;        // speed_value, now_ms, enc_count_left,
                                      // enc_count_right
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [87:0]   m_tdata;             // fwd_drive_left, rev_drive_left,
                                      // fwd_drive_right, rev_drive_right,
                                      // clear_encoders, speed_left, speed_right,
                                      // drive_saturated, zero fill
  logic          cfg_we = 1'b0;
  logic [2:0]    cfg_addr = '0;
  logic [15:0]   cfg_wdata = '0;

  speed_ctrl_scoreboard sb = new();
  bit gaps_on = 1'b1;
  bit hold_request = 1'b0;
  logic [31:0] ms_now = '0;

  dual_motor_pi_speed_control dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // run limit
  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side: random stall bursts and one long hold-off
  initial begin
    wait (!rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // check each result transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) sb.check_result(m_tdata, $time);
  end

  // offer one command and hold it until the transaction completes
  task automatic send_command(func_t fn, logic [7:0] spd, logic [31:0] ms,
                              logic [31:0] cnt_l, logic [31:0] cnt_r);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= fn;
    s_tdata <= {cnt_r, cnt_l, ms, spd};
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_command(fn, {cnt_r, cnt_l, ms, spd});
  endtask

  // all registers in index order, then a write to the unmapped index
  task automatic load_settings(logic [15:0] kp_v, logic [15:0] ki_v,
                               logic [15:0] ppr_v, logic [15:0] per_v,
                               logic [15:0] lim_v, logic [15:0] in_v,
                               logic [15:0] out_v);
    logic [15:0] vals [8];
    vals = '{kp_v, ki_v, ppr_v, per_v, lim_v, in_v, out_v, 16'($urandom)};
    for (int i = 0; i <= REG_UNUSED; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(3'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drain all results, then let a trailing set value command finish
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // counts near a plausible wheel speed, now and then any 32-bit value
  function automatic logic [31:0] enc_count(logic [31:0] adv);
    longint span;
    if ($urandom_range(0, 9) == 0) return $urandom();
    span = longint'(sb.ppr) * adv / 400 + 1;
    if (span > 64'sd1073741824) span = 64'sd1073741824;
    return 32'($urandom_range(0, 32'(2 * span)) - span);
  endfunction

  task automatic run_random(int n);
    func_t fn;
    logic [7:0] spd;
    logic [31:0] adv, per;
    repeat (n) begin
      fn = ($urandom_range(0, 99) < 20) ? FN_SET : func_t'($urandom_range(1, 7));
      spd = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 140) - 70);
      per = (sb.period == 0) ? 1 : sb.period;
      adv = ($urandom_range(0, 2) == 0) ? $urandom_range(0, per - 1)
                                        : $urandom_range(per, 2 * per);
      if ($urandom_range(0, 49) == 0) ms_now = $urandom();
      else ms_now = ms_now + adv;
      send_command(fn, spd, ms_now, enc_count(adv), enc_count(adv));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every command, speed extremes, count extremes, time wrap
    send_command(FN_STOP, 8'd0, 32'd0, 32'd0, 32'd0);
    send_command(FN_SET, 8'd60, 32'd0, 32'd0, 32'd0);
    send_command(FN_FWD, 8'd0, 32'd1000, 32'd2400, -32'sd2400);
    send_command(FN_BACK, 8'd0, 32'd1500, 32'd100, 32'd100);
    send_command(FN_FWD_LEFT, 8'd0, 32'd2500, 32'h7FFF_FFFF, 32'h8000_0000);
    send_command(FN_BACK_LEFT, 8'd0, 32'd3600, 32'h8000_0000, 32'h7FFF_FFFF);
    send_command(FN_SET, 8'hC4, 32'd0, 32'd0, 32'd0);
    send_command(FN_FWD_RIGHT, 8'd0, 32'd4700, -32'sd2640, 32'd1200);
    send_command(FN_BACK_RIGHT, 8'd0, 32'd5800, 32'd0, -32'sd1);
    send_command(FN_SET, 8'h7F, 32'd0, 32'd0, 32'd0);
    send_command(FN_FWD, 8'd0, 32'd6900, 32'd5000, 32'd5000);
    send_command(FN_SET, 8'h80, 32'd0, 32'd0, 32'd0);
    send_command(FN_FWD, 8'd0, 32'd8000, -32'sd5000, -32'sd5000);
    send_command(FN_BACK, 8'd0, 32'd9100, 32'd5000, 32'd5000);
    send_command(FN_STOP, 8'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_command(FN_SET, 8'd0, 32'd0, 32'd0, 32'd0);
    send_command(FN_FWD, 8'd0, 32'd0, 32'd0, 32'd0);
    send_command(FN_STOP, 8'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    send_command(FN_SET, 8'd30, 32'd0, 32'd0, 32'd0);
    send_command(FN_BACK_LEFT, 8'd0, 32'h8000_1000, 32'd7, 32'd9);
    ms_now = 32'h8000_1000;
    run_random(60);

    // largest settings, turn gains above unity
    wait_idle();
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'h01FF, 16'h01FF);
    run_random(80);

    // smallest settings, zero period and zero pulses per revolution
    wait_idle();
    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(80);

    // random settings, one phase with the result side held off
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      load_settings(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 128)),
                    16'($urandom_range(1, 4096)), 16'($urandom_range(1, 300)),
                    16'($urandom), {7'($urandom), 9'($urandom_range(0, 256))},
                    {7'($urandom), 9'($urandom_range(0, 256))});
      if (p == 2) hold_request = 1'b1;
      run_random(80);
    end

    // last stretch at full rate
    wait_idle();
    gaps_on = 1'b0;
    load_settings(KP_RESET, KI_RESET, PPR_RESET, 16'd50, {8'd0, LIMIT_RESET},
                  {7'd0, INNER_RESET}, {7'd0, UNITY_GAIN});
    run_random(100);
    wait_idle();

    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
